>>> hw/rtl/cpec_pkg.sv
// package for the circle pair collision core: types, stage map and per-stage functions
`default_nettype none
package cpec_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned NUM_LANES = 4;

  localparam int unsigned SQ_STEPS = 33;
  localparam int unsigned D2_STEPS = 65;
  localparam int unsigned D3_STEPS = 95;
  localparam int unsigned D4_STEPS = 94;

  localparam int unsigned ST_MUL1  = 1;
  localparam int unsigned ST_SUM1  = ST_MUL1 + 1;
  localparam int unsigned ST_CMP   = ST_SUM1 + 1;
  localparam int unsigned ST_SQ0   = ST_CMP + 1;
  localparam int unsigned ST_PEN   = ST_SQ0 + SQ_STEPS;
  localparam int unsigned ST_MUL2  = ST_PEN + 1;
  localparam int unsigned ST_LOAD2 = ST_MUL2 + 1;
  localparam int unsigned ST_D2    = ST_LOAD2 + 1;
  localparam int unsigned ST_END2  = ST_D2 + D2_STEPS;
  localparam int unsigned ST_MUL3  = ST_END2 + 1;
  localparam int unsigned ST_LOAD3 = ST_MUL3 + 1;
  localparam int unsigned ST_D3    = ST_LOAD3 + 1;
  localparam int unsigned ST_END3  = ST_D3 + D3_STEPS;
  localparam int unsigned ST_MUL4  = ST_END3 + 1;
  localparam int unsigned ST_LOAD4 = ST_MUL4 + 1;
  localparam int unsigned ST_D4    = ST_LOAD4 + 1;
  localparam int unsigned ST_END4  = ST_D4 + D4_STEPS;
  localparam int unsigned ST_SAT   = ST_END4 + 1;
  localparam int unsigned NUM_ST   = ST_SAT + 1;

  localparam logic signed [63:0] SAT_HI = 64'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef struct packed {
    logic [31:0]                   ax;
    logic [31:0]                   ay;
    logic [31:0]                   avx;
    logic [31:0]                   avy;
    logic [31:0]                   bx;
    logic [31:0]                   by;
    logic [31:0]                   bvx;
    logic [31:0]                   bvy;
    logic [31:0]                   am;
    logic [31:0]                   bm;
    logic [31:0]                   dxm;
    logic [31:0]                   dym;
    logic [31:0]                   dvxm;
    logic [31:0]                   dvym;
    logic                          dxs;
    logic                          dys;
    logic                          dvxs;
    logic                          dvys;
    logic [31:0]                   rs;
    logic [7:0][63:0]              pp;
    logic [64:0]                   d2;
    logic [63:0]                   rs2;
    logic [65:0]                   dot;
    logic                          hit;
    logic                          coin;
    logic [65:0]                   sq_rad;
    logic [34:0]                   sq_rem;
    logic [32:0]                   sq_root;
    logic [32:0]                   dlen;
    logic [31:0]                   pen;
    logic [32:0]                   msum;
    logic [NUM_LANES-1:0][94:0]    num;
    logic [NUM_LANES-1:0][34:0]    rem;
    logic [NUM_LANES-1:0][62:0]    q;
    logic [NUM_LANES-1:0]          neg;
    logic [33:0]                   den;
    logic [62:0]                   sx;
    logic [62:0]                   sy;
    logic [61:0]                   pm;
    logic                          ps;
    logic [61:0]                   kam;
    logic [61:0]                   kbm;
    logic [7:0][63:0]              r;
    logic [7:0][31:0]              res;
    logic                          clip;
  } cpec_ctx_t;

  function automatic logic [63:0] sgn_ext62(logic [61:0] m, logic n);
    logic [63:0] v;
    v = {2'b00, m};
    return n ? -v : v;
  endfunction

  function automatic logic [93:0] join_hl(logic [63:0] hi, logic [63:0] lo);
    return {hi[62:0], 31'b0} + {30'b0, lo};
  endfunction

  function automatic cpec_ctx_t f_mul1(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.pp[0] = 64'(c.dxm) * 64'(c.dxm);
    o.pp[1] = 64'(c.dym) * 64'(c.dym);
    o.pp[2] = 64'(c.dvxm) * 64'(c.dxm);
    o.pp[3] = 64'(c.dvym) * 64'(c.dym);
    o.pp[4] = 64'(c.rs) * 64'(c.rs);
    return o;
  endfunction

  function automatic cpec_ctx_t f_sum1(cpec_ctx_t c);
    cpec_ctx_t o;
    logic [65:0] t2;
    logic [65:0] t3;
    o = c;
    t2 = {2'b00, c.pp[2]};
    t3 = {2'b00, c.pp[3]};
    if (c.dvxs ^ c.dxs) begin
      t2 = -t2;
    end
    if (c.dvys ^ c.dys) begin
      t3 = -t3;
    end
    o.d2  = {1'b0, c.pp[0]} + {1'b0, c.pp[1]};
    o.dot = t2 + t3;
    o.rs2 = c.pp[4];
    return o;
  endfunction

  function automatic cpec_ctx_t f_cmp(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.coin    = (c.d2 == '0);
    o.hit     = (c.d2 != '0) && ({1'b0, c.rs2} > c.d2);
    o.sq_rad  = {1'b0, c.d2};
    o.sq_rem  = '0;
    o.sq_root = '0;
    return o;
  endfunction

  function automatic cpec_ctx_t f_sq_step(cpec_ctx_t c);
    cpec_ctx_t o;
    logic [36:0] rn;
    logic [36:0] tr;
    o = c;
    rn = {c.sq_rem, c.sq_rad[65:64]};
    tr = {2'b00, c.sq_root, 2'b01};
    if (rn >= tr) begin
      o.sq_rem  = 35'(rn - tr);
      o.sq_root = {c.sq_root[31:0], 1'b1};
    end else begin
      o.sq_rem  = rn[34:0];
      o.sq_root = {c.sq_root[31:0], 1'b0};
    end
    o.sq_rad = {c.sq_rad[63:0], 2'b00};
    return o;
  endfunction

  function automatic cpec_ctx_t f_pen(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.dlen = c.sq_root;
    o.pen  = c.rs - c.sq_root[31:0];
    return o;
  endfunction

  function automatic cpec_ctx_t f_mul2(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.pp[0] = 64'(c.dxm) * 64'(c.pen);
    o.pp[1] = 64'(c.dym) * 64'(c.pen);
    return o;
  endfunction

  function automatic cpec_ctx_t f_load2(cpec_ctx_t c);
    cpec_ctx_t o;
    logic [65:0] dm;
    o = c;
    dm = c.dot[65] ? -c.dot : c.dot;
    o.num    = '0;
    o.num[0] = {1'b0, c.pp[0], 30'b0};
    o.num[1] = {1'b0, c.pp[1], 30'b0};
    o.num[2] = {dm[64:0], 30'b0};
    o.neg    = '0;
    o.neg[0] = c.dxs;
    o.neg[1] = c.dys;
    o.neg[2] = c.dot[65];
    o.rem    = '0;
    o.q      = '0;
    o.den    = {1'b0, c.dlen};
    return o;
  endfunction

  function automatic cpec_ctx_t f_div_step(cpec_ctx_t c);
    cpec_ctx_t o;
    logic [35:0] rn;
    o = c;
    for (int i = 0; i < NUM_LANES; i++) begin
      rn = {c.rem[i], c.num[i][94]};
      if (rn >= {2'b00, c.den}) begin
        o.rem[i] = 35'(rn - {2'b00, c.den});
        o.q[i]   = {c.q[i][61:0], 1'b1};
      end else begin
        o.rem[i] = rn[34:0];
        o.q[i]   = {c.q[i][61:0], 1'b0};
      end
      o.num[i] = {c.num[i][93:0], 1'b0};
    end
    return o;
  endfunction

  function automatic cpec_ctx_t f_end2(cpec_ctx_t c);
    cpec_ctx_t o;
    logic [62:0] hx;
    logic [62:0] hy;
    o = c;
    hx = {1'b0, c.q[0][62:1]};
    hy = {1'b0, c.q[1][62:1]};
    o.sx = c.neg[0] ? -hx : hx;
    o.sy = c.neg[1] ? -hy : hy;
    o.pm = c.q[2][61:0];
    o.ps = c.neg[2];
    return o;
  endfunction

  function automatic cpec_ctx_t f_mul3(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.pp[0] = 64'(c.pm[30:0]) * 64'(c.bm);
    o.pp[1] = 64'(c.pm[61:31]) * 64'(c.bm);
    o.pp[2] = 64'(c.pm[30:0]) * 64'(c.am);
    o.pp[3] = 64'(c.pm[61:31]) * 64'(c.am);
    o.msum  = {1'b0, c.am} + {1'b0, c.bm};
    return o;
  endfunction

  function automatic cpec_ctx_t f_load3(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.num    = '0;
    o.num[0] = {join_hl(c.pp[1], c.pp[0]), 1'b0};
    o.num[1] = {join_hl(c.pp[3], c.pp[2]), 1'b0};
    o.neg    = {2'b00, c.ps, c.ps};
    o.rem    = '0;
    o.q      = '0;
    o.den    = {1'b0, c.msum};
    return o;
  endfunction

  function automatic cpec_ctx_t f_end3(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.kam = c.q[0][61:0];
    o.kbm = c.q[1][61:0];
    return o;
  endfunction

  function automatic cpec_ctx_t f_mul4(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.pp[0] = 64'(c.dxm) * 64'(c.kam[30:0]);
    o.pp[1] = 64'(c.dxm) * 64'(c.kam[61:31]);
    o.pp[2] = 64'(c.dym) * 64'(c.kam[30:0]);
    o.pp[3] = 64'(c.dym) * 64'(c.kam[61:31]);
    o.pp[4] = 64'(c.dxm) * 64'(c.kbm[30:0]);
    o.pp[5] = 64'(c.dxm) * 64'(c.kbm[61:31]);
    o.pp[6] = 64'(c.dym) * 64'(c.kbm[30:0]);
    o.pp[7] = 64'(c.dym) * 64'(c.kbm[61:31]);
    return o;
  endfunction

  function automatic cpec_ctx_t f_load4(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.num[0] = {join_hl(c.pp[1], c.pp[0]), 1'b0};
    o.num[1] = {join_hl(c.pp[3], c.pp[2]), 1'b0};
    o.num[2] = {join_hl(c.pp[5], c.pp[4]), 1'b0};
    o.num[3] = {join_hl(c.pp[7], c.pp[6]), 1'b0};
    o.neg[0] = c.dxs ^ c.ps;
    o.neg[1] = c.dys ^ c.ps;
    o.neg[2] = c.dxs ^ c.ps;
    o.neg[3] = c.dys ^ c.ps;
    o.rem    = '0;
    o.q      = '0;
    o.den    = {1'b0, c.dlen};
    return o;
  endfunction

  function automatic cpec_ctx_t f_end4(cpec_ctx_t c);
    cpec_ctx_t o;
    logic        vel;
    logic [63:0] sx64;
    logic [63:0] sy64;
    logic [63:0] ax64;
    logic [63:0] ay64;
    logic [63:0] bx64;
    logic [63:0] by64;
    logic [63:0] avx64;
    logic [63:0] avy64;
    logic [63:0] bvx64;
    logic [63:0] bvy64;
    o = c;
    vel   = c.hit && (c.msum != '0);
    sx64  = {c.sx[62], c.sx};
    sy64  = {c.sy[62], c.sy};
    ax64  = {{32{c.ax[31]}}, c.ax};
    ay64  = {{32{c.ay[31]}}, c.ay};
    bx64  = {{32{c.bx[31]}}, c.bx};
    by64  = {{32{c.by[31]}}, c.by};
    avx64 = {{32{c.avx[31]}}, c.avx};
    avy64 = {{32{c.avy[31]}}, c.avy};
    bvx64 = {{32{c.bvx[31]}}, c.bvx};
    bvy64 = {{32{c.bvy[31]}}, c.bvy};
    o.r[0] = c.hit ? ax64 - sx64 : ax64;
    o.r[1] = c.hit ? ay64 - sy64 : ay64;
    o.r[4] = c.hit ? bx64 + sx64 : bx64;
    o.r[5] = c.hit ? by64 + sy64 : by64;
    o.r[2] = vel ? avx64 + sgn_ext62(c.q[0][61:0], c.neg[0]) : avx64;
    o.r[3] = vel ? avy64 + sgn_ext62(c.q[1][61:0], c.neg[1]) : avy64;
    o.r[6] = vel ? bvx64 - sgn_ext62(c.q[2][61:0], c.neg[2]) : bvx64;
    o.r[7] = vel ? bvy64 - sgn_ext62(c.q[3][61:0], c.neg[3]) : bvy64;
    return o;
  endfunction

  function automatic cpec_ctx_t f_sat(cpec_ctx_t c);
    cpec_ctx_t o;
    o = c;
    o.clip = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if ($signed(c.r[i]) > SAT_HI) begin
        o.res[i] = SAT_HI[WORD_BITS-1:0];
        o.clip   = 1'b1;
      end else if ($signed(c.r[i]) < SAT_LO) begin
        o.res[i] = SAT_LO[WORD_BITS-1:0];
        o.clip   = 1'b1;
      end else begin
        o.res[i] = c.r[i][WORD_BITS-1:0];
      end
    end
    return o;
  endfunction

  function automatic cpec_ctx_t stage_fn(cpec_ctx_t c, int unsigned k);
    cpec_ctx_t o;
    o = c;
    if (k == ST_MUL1) begin
      o = f_mul1(c);
    end else if (k == ST_SUM1) begin
      o = f_sum1(c);
    end else if (k == ST_CMP) begin
      o = f_cmp(c);
    end else if (k >= ST_SQ0 && k < ST_PEN) begin
      o = f_sq_step(c);
    end else if (k == ST_PEN) begin
      o = f_pen(c);
    end else if (k == ST_MUL2) begin
      o = f_mul2(c);
    end else if (k == ST_LOAD2) begin
      o = f_load2(c);
    end else if ((k >= ST_D2 && k < ST_END2) || (k >= ST_D3 && k < ST_END3) ||
                 (k >= ST_D4 && k < ST_END4)) begin
      o = f_div_step(c);
    end else if (k == ST_END2) begin
      o = f_end2(c);
    end else if (k == ST_MUL3) begin
      o = f_mul3(c);
    end else if (k == ST_LOAD3) begin
      o = f_load3(c);
    end else if (k == ST_END3) begin
      o = f_end3(c);
    end else if (k == ST_MUL4) begin
      o = f_mul4(c);
    end else if (k == ST_LOAD4) begin
      o = f_load4(c);
    end else if (k == ST_END4) begin
      o = f_end4(c);
    end else if (k == ST_SAT) begin
      o = f_sat(c);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/circle_pair_elastic_collision_core.sv
// top level of the circle pair elastic collision core
// Resolves one circle pair per request and accepts a new request every cycle while the
// pipeline is not stalled. A request runs through a fixed pipeline of 302 register
// stages; the depth comes from the bit-serial square root (33 stages) and the three
// one-bit-per-stage division sections (65, 95 and 94 stages) chained behind it.
// The whole pipeline advances together; it holds only while a result sits on the output
// and out_stall is high, and in_stall reflects exactly that condition.
`default_nettype none
module circle_pair_elastic_collision_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_a_x,
  input  wire logic [31:0] in_a_y,
  input  wire logic [31:0] in_a_vx,
  input  wire logic [31:0] in_a_vy,
  input  wire logic [30:0] in_a_rad,
  input  wire logic [31:0] in_a_mass,
  input  wire logic [31:0] in_b_x,
  input  wire logic [31:0] in_b_y,
  input  wire logic [31:0] in_b_vx,
  input  wire logic [31:0] in_b_vy,
  input  wire logic [30:0] in_b_rad,
  input  wire logic [31:0] in_b_mass,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_new_a_x,
  output logic [31:0]      out_new_a_y,
  output logic [31:0]      out_new_a_vx,
  output logic [31:0]      out_new_a_vy,
  output logic [31:0]      out_new_b_x,
  output logic [31:0]      out_new_b_y,
  output logic [31:0]      out_new_b_vx,
  output logic [31:0]      out_new_b_vy,
  output logic             out_hit,
  output logic             out_coincident,
  output logic             out_clipped
);
  import cpec_pkg::*;

  cpec_ctx_t           pipe_r   [NUM_ST];
  cpec_ctx_t           pipe_nxt [NUM_ST];
  logic [NUM_ST-1:0]   vld_r;
  logic [NUM_ST-1:0]   vld_nxt;
  logic                adv;
  logic [32:0]         dx;
  logic [32:0]         dy;
  logic [32:0]         dvx;
  logic [32:0]         dvy;

  assign adv      = !(vld_r[NUM_ST-1] && out_stall);
  assign in_stall = !adv;
  assign vld_nxt  = {vld_r[NUM_ST-2:0], in_valid};

  // input stage: differences as sign and magnitude
  always_comb begin
    dx  = {in_b_x[31], in_b_x} - {in_a_x[31], in_a_x};
    dy  = {in_b_y[31], in_b_y} - {in_a_y[31], in_a_y};
    dvx = {in_b_vx[31], in_b_vx} - {in_a_vx[31], in_a_vx};
    dvy = {in_b_vy[31], in_b_vy} - {in_a_vy[31], in_a_vy};
    pipe_nxt[0]      = '0;
    pipe_nxt[0].ax   = in_a_x;
    pipe_nxt[0].ay   = in_a_y;
    pipe_nxt[0].avx  = in_a_vx;
    pipe_nxt[0].avy  = in_a_vy;
    pipe_nxt[0].bx   = in_b_x;
    pipe_nxt[0].by   = in_b_y;
    pipe_nxt[0].bvx  = in_b_vx;
    pipe_nxt[0].bvy  = in_b_vy;
    pipe_nxt[0].am   = in_a_mass;
    pipe_nxt[0].bm   = in_b_mass;
    pipe_nxt[0].dxs  = dx[32];
    pipe_nxt[0].dys  = dy[32];
    pipe_nxt[0].dvxs = dvx[32];
    pipe_nxt[0].dvys = dvy[32];
    pipe_nxt[0].dxm  = dx[32] ? 32'(-dx) : dx[31:0];
    pipe_nxt[0].dym  = dy[32] ? 32'(-dy) : dy[31:0];
    pipe_nxt[0].dvxm = dvx[32] ? 32'(-dvx) : dvx[31:0];
    pipe_nxt[0].dvym = dvy[32] ? 32'(-dvy) : dvy[31:0];
    pipe_nxt[0].rs   = {1'b0, in_a_rad} + {1'b0, in_b_rad};
    for (int unsigned k = 1; k < NUM_ST; k++) begin
      pipe_nxt[k] = stage_fn(pipe_r[k-1], k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int unsigned k = 0; k < NUM_ST; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  assign out_valid      = vld_r[NUM_ST-1];
  assign out_new_a_x    = pipe_r[NUM_ST-1].res[0];
  assign out_new_a_y    = pipe_r[NUM_ST-1].res[1];
  assign out_new_a_vx   = pipe_r[NUM_ST-1].res[2];
  assign out_new_a_vy   = pipe_r[NUM_ST-1].res[3];
  assign out_new_b_x    = pipe_r[NUM_ST-1].res[4];
  assign out_new_b_y    = pipe_r[NUM_ST-1].res[5];
  assign out_new_b_vx   = pipe_r[NUM_ST-1].res[6];
  assign out_new_b_vy   = pipe_r[NUM_ST-1].res[7];
  assign out_hit        = pipe_r[NUM_ST-1].hit;
  assign out_coincident = pipe_r[NUM_ST-1].coin;
  assign out_clipped    = pipe_r[NUM_ST-1].clip;

endmodule
`default_nettype wire

>>> hw/rtl/cpec_checker.sv
// port-level checker for the circle pair collision core and its bind
`default_nettype none
module cpec_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_new_a_x,
  input wire logic [31:0] out_new_a_y,
  input wire logic [31:0] out_new_a_vx,
  input wire logic [31:0] out_new_a_vy,
  input wire logic [31:0] out_new_b_x,
  input wire logic [31:0] out_new_b_y,
  input wire logic [31:0] out_new_b_vx,
  input wire logic [31:0] out_new_b_vy,
  input wire logic        out_hit,
  input wire logic        out_coincident,
  input wire logic        out_clipped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_new_a_x) && $stable(out_new_a_y) &&
    $stable(out_new_a_vx) && $stable(out_new_a_vy) && $stable(out_new_b_x) &&
    $stable(out_new_b_y) && $stable(out_new_b_vx) && $stable(out_new_b_vy) &&
    $stable(out_hit) && $stable(out_coincident) && $stable(out_clipped))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_hit_coin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_coincident))
    else $error("hit and coincident together");

  a_no_clip_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> !out_clipped)
    else $error("clipped on passthrough");

endmodule

bind circle_pair_elastic_collision_core cpec_checker u_cpec_checker (.*);
`default_nettype wire
